@@ rtl/modbus_rtu_register_slave_core_macros.svh @@
// Assertion macros for the Modbus RTU register slave.
// Expects signals clk and rst_n in the scope of use.
`ifndef MODBUS_RTU_REGISTER_SLAVE_CORE_MACROS_SVH
`define MODBUS_RTU_REGISTER_SLAVE_CORE_MACROS_SVH

// Checked on every edge outside reset.
`define MRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define MRS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/mrs_pkg.sv @@
// Shared constants, types and the CRC-16 byte step for the Modbus RTU slave.
// No dependencies.
`timescale 1ns / 1ps

package mrs_pkg;

    localparam int READ_REGS   = 24;
    localparam int READ_AW     = $clog2(READ_REGS);
    localparam int WRITE_LIMIT = 12;
    localparam int MIN_FRAME   = 8;
    localparam int MAX_FRAME   = 256;
    localparam int HDR_BYTES   = 6;

    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [8:0]  LEN_SAT  = 9'd511;

    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FC_EXC_FLAG     = 8'h80;
    localparam logic [7:0] EXC_ILLEGAL_FC  = 8'h01;

    typedef enum logic [1:0] {
        KIND_READ,
        KIND_WRITE,
        KIND_EXC
    } reply_kind_t;

    typedef struct packed {
        reply_kind_t kind;
        logic [7:0]  fc;
        logic [15:0] start;
        logic [15:0] count;
    } reply_desc_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/mrs_channels.sv @@
// Valid/ready channel interfaces: request, response and configuration.
// Depends on nothing.
`timescale 1ns / 1ps

interface mrs_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  rx_byte;
    logic        rx_last;
    logic [4:0]  sensor_index;
    logic [15:0] sensor_value;

    modport source (output valid, opcode, rx_byte, rx_last, sensor_index, sensor_value,
                    input ready);
    modport sink   (input valid, opcode, rx_byte, rx_last, sensor_index, sensor_value,
                    output ready);
endinterface

interface mrs_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        write_valid;
    logic [3:0]  write_index;
    logic [15:0] write_value;

    modport source (output valid, tx_byte, tx_last, write_valid, write_index, write_value,
                    input ready);
    modport sink   (input valid, tx_byte, tx_last, write_valid, write_index, write_value,
                    output ready);
endinterface

interface mrs_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] device_address;

    modport source (output valid, device_address, input ready);
    modport sink   (input valid, device_address, output ready);
endinterface

@@ rtl/mrs_sensor_mem.sv @@
// Sensor read map: synchronous RAM, one write and one read port, registered read data.
// Per-entry valid bits make never-written entries read as zero after reset. Uses mrs_pkg.
`timescale 1ns / 1ps

module mrs_sensor_mem
    import mrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [READ_AW-1:0] wr_addr,
    input  logic [15:0]        wr_data,
    input  logic               rd_en,
    input  logic [READ_AW-1:0] rd_addr,
    output logic [15:0]        rd_data
);

    logic [15:0]          mem [READ_REGS];
    logic [READ_REGS-1:0] filled_reg;
    logic [15:0]          q_reg;
    logic                 q_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg  <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                filled_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                q_valid_reg <= filled_reg[rd_addr];
            end
        end
    end

    assign rd_data = q_valid_reg ? q_reg : 16'h0000;

endmodule

@@ rtl/mrs_rx_frame.sv @@
// Request framing: header capture, CRC over all but the last two bytes, frame checks
// and reply dispatch. Uses mrs_pkg.
`timescale 1ns / 1ps

module mrs_rx_frame
    import mrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        beat,
    input  logic [7:0]  rx_byte,
    input  logic        rx_last,
    input  logic [7:0]  device_address,
    output logic        start,
    output reply_desc_t desc
);

    logic [15:0]          crc_reg, crc_next;
    logic [15:0]          delay_reg, delay_next;
    logic [5:0][7:0]      hdr_reg, hdr_next;
    logic [8:0]           len_reg, len_next;
    logic [15:0]          got;
    logic [16:0]          span;
    logic                 frame_ok;

    always_comb
    begin
        hdr_next = hdr_reg;
        for (int k = 0; k < HDR_BYTES; k++)
        begin
            if (len_reg == 9'(k))
            begin
                hdr_next[k] = rx_byte;
            end
        end
        crc_next   = (len_reg >= 9'd2) ? crc16_byte(crc_reg, delay_reg[15:8]) : crc_reg;
        delay_next = {delay_reg[7:0], rx_byte};
        len_next   = (len_reg < LEN_SAT) ? len_reg + 9'd1 : len_reg;
        got        = {rx_byte, delay_reg[7:0]};

        desc.fc    = hdr_next[1];
        desc.start = {hdr_next[2], hdr_next[3]};
        desc.count = {hdr_next[4], hdr_next[5]};
        span       = {1'b0, desc.start} + {1'b0, desc.count};

        frame_ok = (len_next >= 9'(MIN_FRAME)) && (len_next <= 9'(MAX_FRAME))
                && (hdr_next[0] == device_address) && (got == crc_next);

        case (desc.fc)
            FC_READ_HOLDING:
            begin
                desc.kind = KIND_READ;
                start     = beat && rx_last && frame_ok && (span <= 17'(READ_REGS));
            end
            FC_WRITE_SINGLE:
            begin
                desc.kind = KIND_WRITE;
                start     = beat && rx_last && frame_ok && (desc.start < 16'(WRITE_LIMIT));
            end
            default:
            begin
                desc.kind = KIND_EXC;
                start     = beat && rx_last && frame_ok;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_SEED;
            delay_reg <= '0;
            hdr_reg   <= '0;
            len_reg   <= '0;
        end
        else if (beat)
        begin
            if (rx_last)
            begin
                crc_reg   <= CRC_SEED;
                delay_reg <= '0;
                hdr_reg   <= '0;
                len_reg   <= '0;
            end
            else
            begin
                crc_reg   <= crc_next;
                delay_reg <= delay_next;
                hdr_reg   <= hdr_next;
                len_reg   <= len_next;
            end
        end
    end

endmodule

@@ rtl/mrs_tx_engine.sv @@
// Response sequencer: header bytes, map words read from the sensor RAM, CRC low/high,
// into an output register. Uses mrs_pkg, mrs_rsp_if and the assertion macros.
`timescale 1ns / 1ps
`include "modbus_rtu_register_slave_core_macros.svh"

module mrs_tx_engine
    import mrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  reply_desc_t        desc,
    input  logic [7:0]         device_address,
    output logic               busy,
    output logic               rd_en,
    output logic [READ_AW-1:0] rd_addr,
    input  logic [15:0]        rd_data,
    mrs_rsp_if.source          rsp
);

    typedef enum logic [2:0] {
        T_IDLE,
        T_HEAD,
        T_RDREQ,
        T_RDHI,
        T_RDLO,
        T_CRCLO,
        T_CRCHI
    } tx_state_t;

    tx_state_t          state_reg, state_next;
    logic [5:0][7:0]    hbuf_reg, hbuf_next;
    logic [2:0]         hidx_reg, hidx_next;
    logic [2:0]         hlen_reg, hlen_next;
    logic [READ_AW-1:0] ptr_reg, ptr_next;
    logic [READ_AW-1:0] left_reg, left_next;
    logic [15:0]        crc_reg, crc_next;
    logic               wr_reg, wr_next;
    logic [3:0]         widx_reg, widx_next;
    logic [15:0]        wval_reg, wval_next;

    logic               ov_reg, ov_next;
    logic [7:0]         byte_reg, byte_next;
    logic               last_reg, last_next;
    logic               wv_reg, wv_next;
    logic [3:0]         oidx_reg, oidx_next;
    logic [15:0]        oval_reg, oval_next;

    logic               can_emit;
    logic               emit;
    logic [7:0]         ebyte;
    logic               elast;

    assign can_emit = !ov_reg || rsp.ready;

    always_comb
    begin
        state_next = state_reg;
        hbuf_next  = hbuf_reg;
        hidx_next  = hidx_reg;
        hlen_next  = hlen_reg;
        ptr_next   = ptr_reg;
        left_next  = left_reg;
        crc_next   = crc_reg;
        wr_next    = wr_reg;
        widx_next  = widx_reg;
        wval_next  = wval_reg;
        emit       = 1'b0;
        ebyte      = 8'h00;
        elast      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = ptr_reg;

        case (state_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    state_next   = T_HEAD;
                    hidx_next    = '0;
                    crc_next     = CRC_SEED;
                    ptr_next     = desc.start[READ_AW-1:0];
                    left_next    = desc.count[READ_AW-1:0];
                    widx_next    = desc.start[3:0];
                    wval_next    = desc.count;
                    hbuf_next    = '0;
                    hbuf_next[0] = device_address;
                    case (desc.kind)
                        KIND_READ:
                        begin
                            hbuf_next[1] = FC_READ_HOLDING;
                            hbuf_next[2] = {desc.count[6:0], 1'b0};
                            hlen_next    = 3'd3;
                            wr_next      = 1'b0;
                        end
                        KIND_WRITE:
                        begin
                            hbuf_next[1] = FC_WRITE_SINGLE;
                            hbuf_next[2] = desc.start[15:8];
                            hbuf_next[3] = desc.start[7:0];
                            hbuf_next[4] = desc.count[15:8];
                            hbuf_next[5] = desc.count[7:0];
                            hlen_next    = 3'd6;
                            wr_next      = 1'b1;
                        end
                        default:
                        begin
                            hbuf_next[1] = desc.fc | FC_EXC_FLAG;
                            hbuf_next[2] = EXC_ILLEGAL_FC;
                            hlen_next    = 3'd3;
                            wr_next      = 1'b0;
                        end
                    endcase
                end
            end
            T_HEAD:
            begin
                ebyte = hbuf_reg[hidx_reg];
                if (can_emit)
                begin
                    emit      = 1'b1;
                    crc_next  = crc16_byte(crc_reg, ebyte);
                    hidx_next = hidx_reg + 3'd1;
                    if (hidx_reg == hlen_reg - 3'd1)
                    begin
                        state_next = (wr_reg || left_reg == '0 || hlen_reg != 3'd3
                                      || hbuf_reg[1] != FC_READ_HOLDING) ? T_CRCLO : T_RDREQ;
                    end
                end
            end
            T_RDREQ:
            begin
                rd_en      = 1'b1;
                state_next = T_RDHI;
            end
            T_RDHI:
            begin
                ebyte = rd_data[15:8];
                if (can_emit)
                begin
                    emit       = 1'b1;
                    crc_next   = crc16_byte(crc_reg, ebyte);
                    state_next = T_RDLO;
                end
            end
            T_RDLO:
            begin
                ebyte = rd_data[7:0];
                if (can_emit)
                begin
                    emit       = 1'b1;
                    crc_next   = crc16_byte(crc_reg, ebyte);
                    ptr_next   = ptr_reg + READ_AW'(1);
                    left_next  = left_reg - READ_AW'(1);
                    state_next = (left_reg == READ_AW'(1)) ? T_CRCLO : T_RDREQ;
                end
            end
            T_CRCLO:
            begin
                ebyte = crc_reg[7:0];
                if (can_emit)
                begin
                    emit       = 1'b1;
                    state_next = T_CRCHI;
                end
            end
            T_CRCHI:
            begin
                ebyte = crc_reg[15:8];
                elast = 1'b1;
                if (can_emit)
                begin
                    emit       = 1'b1;
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase

        ov_next   = ov_reg && !rsp.ready;
        byte_next = byte_reg;
        last_next = last_reg;
        wv_next   = wv_reg;
        oidx_next = oidx_reg;
        oval_next = oval_reg;
        if (emit)
        begin
            ov_next   = 1'b1;
            byte_next = ebyte;
            last_next = elast;
            wv_next   = elast && wr_reg;
            oidx_next = (elast && wr_reg) ? widx_reg : 4'h0;
            oval_next = (elast && wr_reg) ? wval_reg : 16'h0000;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            ov_reg    <= 1'b0;
            hbuf_reg  <= '0;
            hidx_reg  <= '0;
            hlen_reg  <= '0;
            ptr_reg   <= '0;
            left_reg  <= '0;
            crc_reg   <= CRC_SEED;
            wr_reg    <= 1'b0;
            widx_reg  <= '0;
            wval_reg  <= '0;
            byte_reg  <= '0;
            last_reg  <= 1'b0;
            wv_reg    <= 1'b0;
            oidx_reg  <= '0;
            oval_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            hbuf_reg  <= hbuf_next;
            hidx_reg  <= hidx_next;
            hlen_reg  <= hlen_next;
            ptr_reg   <= ptr_next;
            left_reg  <= left_next;
            crc_reg   <= crc_next;
            wr_reg    <= wr_next;
            widx_reg  <= widx_next;
            wval_reg  <= wval_next;
            byte_reg  <= byte_next;
            last_reg  <= last_next;
            wv_reg    <= wv_next;
            oidx_reg  <= oidx_next;
            oval_reg  <= oval_next;
        end
    end

    assign busy            = (state_reg != T_IDLE);
    assign rsp.valid       = ov_reg;
    assign rsp.tx_byte     = byte_reg;
    assign rsp.tx_last     = last_reg;
    assign rsp.write_valid = wv_reg;
    assign rsp.write_index = oidx_reg;
    assign rsp.write_value = oval_reg;

    `MRS_ASSERT(a_start_when_idle, start |-> (state_reg == T_IDLE), "reply started while busy")
    `MRS_ASSERT(a_rd_in_map, rd_en |-> (rd_addr < READ_AW'(READ_REGS)), "read beyond map")
    `MRS_ASSERT(a_wv_on_last, (ov_reg && wv_reg) |-> last_reg, "write flag off last beat")
    `MRS_ASSERT(a_crchi_ends, (state_reg == T_CRCHI && emit) |=> (state_reg == T_IDLE),
                "reply did not end after CRC high")
    `MRS_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !rsp.valid, "response valid in reset")

endmodule

@@ rtl/modbus_rtu_register_slave_core.sv @@
// Modbus RTU register slave top level: functions 0x03 and 0x06, exception reply.
// Depends on mrs_pkg, mrs_channels, mrs_sensor_mem, mrs_rx_frame, mrs_tx_engine.
//
// Channels: req carries beats of two kinds. opcode 0 is one request frame byte
// (rx_last marks the frame end); opcode 1 stores sensor_value into read-map slot
// sensor_index (slots 24 and up are ignored). rsp carries one response byte per
// beat, tx_last on the CRC high byte, write_valid/index/value on the last byte of
// a write-single-register reply. cfg writes the slave address (reset 1), ready
// always high.
// A frame byte or sensor beat is taken whenever req.ready is high. After the edge that
// accepts the last byte of an answered frame, the sequencer enters its header state and
// then registers the first reply byte; header and CRC bytes go out one per cycle unless
// rsp stalls, each map word as a RAM read and two bytes. req.ready is low during a reply.
// Reset clears framing state and the read map (zero), address to 1, no reply.
// When rsp stalls, the output register holds and the sequencer waits.
`timescale 1ns / 1ps

module modbus_rtu_register_slave_core
    import mrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mrs_req_if.sink   req,
    mrs_rsp_if.source rsp,
    mrs_cfg_if.sink   cfg
);

    logic [7:0]         addr_reg;
    logic               accept;
    logic               busy;
    logic               start;
    reply_desc_t        desc;
    logic               rd_en;
    logic [READ_AW-1:0] rd_addr;
    logic [15:0]        rd_data;
    logic               sensor_wr;

    assign req.ready = !busy;
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;
    assign sensor_wr = accept && req.opcode && (req.sensor_index < 5'(READ_REGS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= 8'h01;
        end
        else if (cfg.valid)
        begin
            addr_reg <= cfg.device_address;
        end
    end

    mrs_sensor_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (sensor_wr),
        .wr_addr (req.sensor_index[READ_AW-1:0]),
        .wr_data (req.sensor_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mrs_rx_frame u_rx (
        .clk            (clk),
        .rst_n          (rst_n),
        .beat           (accept && !req.opcode),
        .rx_byte        (req.rx_byte),
        .rx_last        (req.rx_last),
        .device_address (addr_reg),
        .start          (start),
        .desc           (desc)
    );

    mrs_tx_engine u_tx (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .desc           (desc),
        .device_address (addr_reg),
        .busy           (busy),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .rsp            (rsp)
    );

endmodule
